// ----- src/dwgd_pkg.sv -----
package dwgd_pkg;

	localparam int STEP_W = 3;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_WAIT   = 3'd0;
	localparam step_t STEP_CHECK  = 3'd1;
	localparam step_t STEP_UPDATE = 3'd2;
	localparam step_t STEP_PEEL   = 3'd3;
	localparam step_t STEP_RESULT = 3'd4;
	localparam step_t STEP_RETURN = 3'd5;

	typedef enum logic [1:0] {
		CMD_ACQUIRE  = 2'd0,
		CMD_ACQUIRED = 2'd1,
		CMD_RELEASE  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_UPDATE,
		OP_PEEL,
		OP_RESULT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_BEAT,
		COND_HALTED,
		COND_CHANGED,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	function automatic ctrl_word_t prog_rom(step_t pc);
		ctrl_word_t w;
		unique case (pc)
			STEP_WAIT:   w = '{op: OP_LOAD,   cond: COND_NO_BEAT,  target: STEP_WAIT};
			STEP_CHECK:  w = '{op: OP_NONE,   cond: COND_HALTED,   target: STEP_RESULT};
			STEP_UPDATE: w = '{op: OP_UPDATE, cond: COND_NEVER,    target: STEP_WAIT};
			STEP_PEEL:   w = '{op: OP_PEEL,   cond: COND_CHANGED,  target: STEP_PEEL};
			STEP_RESULT: w = '{op: OP_RESULT, cond: COND_OUT_BUSY, target: STEP_RESULT};
			default:     w = '{op: OP_NONE,   cond: COND_ALWAYS,   target: STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ----- src/deadlock_wait_graph_detector.sv -----
// Deadlock detector over a wait-for graph of THREADS threads and MUTEXES mutexes. Each input
// beat is a lock event that sets or clears the wait and hold edges of one thread and one
// mutex, after which the whole graph is checked for a cycle by peeling nodes with no edge
// to a live node, one round of all nodes per cycle. The peeling rounds number at most
// THREADS + MUTEXES + 1, so the peel loop sets the rate. Once a deadlock is found it is
// latched, later events are ignored, and each of them reports deadlock.
// One result beat follows every input beat; the next event is taken while a result waits.
module deadlock_wait_graph_detector #(
	parameter int THREADS = 16,
	parameter int MUTEXES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [3:0] thread_index,
	input  logic [3:0] mutex_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       deadlock
);

	logic [THREADS-1:0][MUTEXES-1:0] waits_q;
	logic [MUTEXES-1:0][THREADS-1:0] held_q;
	logic [THREADS-1:0]              tlive_q;
	logic [MUTEXES-1:0]              mlive_q;
	logic [THREADS-1:0]              tnext;
	logic [MUTEXES-1:0]              mnext;
	logic [THREADS-1:0]              tsel;
	logic [MUTEXES-1:0]              msel;
	dwgd_pkg::step_t                 pc_q;
	dwgd_pkg::step_t                 pc_d;
	dwgd_pkg::ctrl_word_t            word;
	logic [1:0]                      cmd_q;
	logic [3:0]                      thread_q;
	logic [3:0]                      mutex_q;
	logic                            halted_q;
	logic                            out_valid_q;
	logic                            deadlock_q;
	logic                            in_beat;
	logic                            out_busy;
	logic                            changed;
	logic                            jump;
	logic                            found;

	assign word      = dwgd_pkg::prog_rom(pc_q);
	assign in_ready  = (word.op == dwgd_pkg::OP_LOAD);
	assign in_beat   = in_valid && in_ready;
	assign out_busy  = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign deadlock  = deadlock_q;
	assign found     = halted_q || (|tlive_q) || (|mlive_q);

	always_comb begin
		for (int i = 0; i < THREADS; i++) begin
			tsel[i]  = ({3'b000, thread_q} == 7'(i));
			tnext[i] = tlive_q[i] && (|(waits_q[i] & mlive_q));
		end
		for (int j = 0; j < MUTEXES; j++) begin
			msel[j]  = ({3'b000, mutex_q} == 7'(j));
			mnext[j] = mlive_q[j] && (|(held_q[j] & tlive_q));
		end
		changed = (tnext != tlive_q) || (mnext != mlive_q);
	end

	always_comb begin
		unique case (word.cond)
			dwgd_pkg::COND_NEVER:    jump = 1'b0;
			dwgd_pkg::COND_ALWAYS:   jump = 1'b1;
			dwgd_pkg::COND_NO_BEAT:  jump = !in_beat;
			dwgd_pkg::COND_HALTED:   jump = halted_q;
			dwgd_pkg::COND_CHANGED:  jump = changed;
			dwgd_pkg::COND_OUT_BUSY: jump = out_busy;
			default:                 jump = 1'b1;
		endcase
		pc_d = jump ? word.target : pc_q + dwgd_pkg::step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= dwgd_pkg::STEP_WAIT;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
			waits_q     <= '0;
			held_q      <= '0;
		end else begin
			pc_q <= pc_d;
			if (word.op == dwgd_pkg::OP_RESULT && !out_busy) begin
				out_valid_q <= 1'b1;
				halted_q    <= found;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (word.op == dwgd_pkg::OP_UPDATE) begin
				for (int i = 0; i < THREADS; i++) begin
					for (int j = 0; j < MUTEXES; j++) begin
						if (tsel[i] && msel[j]) begin
							if (cmd_q == dwgd_pkg::CMD_ACQUIRE) begin
								waits_q[i][j] <= 1'b1;
							end else if (cmd_q == dwgd_pkg::CMD_ACQUIRED) begin
								waits_q[i][j] <= 1'b0;
								held_q[j][i]  <= 1'b1;
							end else if (cmd_q == dwgd_pkg::CMD_RELEASE) begin
								held_q[j][i]  <= 1'b0;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_q    <= command;
			thread_q <= thread_index;
			mutex_q  <= mutex_index;
		end
		if (word.op == dwgd_pkg::OP_UPDATE) begin
			tlive_q <= '1;
			mlive_q <= '1;
		end else if (word.op == dwgd_pkg::OP_PEEL) begin
			tlive_q <= tnext;
			mlive_q <= mnext;
		end
		if (word.op == dwgd_pkg::OP_RESULT && !out_busy) begin
			deadlock_q <= found;
		end
	end

	a_halted_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("deadlock latch cleared");

	a_deadlock_latched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && deadlock_q |-> halted_q)
		else $error("deadlock reported without latch");

	a_peel_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == dwgd_pkg::STEP_PEEL |=> (tlive_q & ~$past(tlive_q)) == '0)
		else $error("live thread set grew while peeling");

	a_graph_stable: assert property (@(posedge clk) disable iff (!arst_n)
		word.op != dwgd_pkg::OP_UPDATE |=> $stable(waits_q) && $stable(held_q))
		else $error("graph changed outside update step");

	a_no_update_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && in_beat |-> ##2 pc_q == dwgd_pkg::STEP_RESULT)
		else $error("event processed after deadlock");

endmodule

// ----- test/tb_deadlock_wait_graph_detector.sv -----
module tb_deadlock_wait_graph_detector;

	typedef logic [15:0][15:0] adj_t;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int MAX_SHOWN = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = 2'd0;
	logic [3:0] thread_index = 4'd0;
	logic [3:0] mutex_index = 4'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic deadlock;

	// Predicted graph and latch, updated as each beat is accepted.
	adj_t wait_edges = '0;
	adj_t hold_edges = '0;
	bit latched = 1'b0;
	bit deadlock_due_q[$];

	bit quiet = 1'b0;
	int mismatches = 0;
	int events_sent = 0;
	int results_checked = 0;
	int cmd_count[4] = '{0, 0, 0, 0};
	int latch_event = -1;
	int halted_events = 0;

	deadlock_wait_graph_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.thread_index(thread_index),
		.mutex_index(mutex_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.deadlock(deadlock)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("deadlock_wait_graph_detector regression: fail");
		$finish;
	end

	function automatic void apply_event(input logic [1:0] cmd, input logic [3:0] t,
			input logic [3:0] m, inout adj_t w, inout adj_t h);
		case (cmd)
			dwgd_pkg::CMD_ACQUIRE: begin
				w[t][m] = 1'b1;
			end
			dwgd_pkg::CMD_ACQUIRED: begin
				w[t][m] = 1'b0;
				h[m][t] = 1'b1;
			end
			dwgd_pkg::CMD_RELEASE: begin
				h[m][t] = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	// Nodes with no edge into the live set are peeled until nothing changes;
	// whatever survives lies on or leads into a cycle.
	function automatic bit has_cycle(input adj_t w, input adj_t h);
		logic [15:0] t_live;
		logic [15:0] m_live;
		logic [15:0] t_next;
		logic [15:0] m_next;
		bit changed;
		int i;
		t_live = '1;
		m_live = '1;
		changed = 1'b1;
		while (changed) begin
			t_next = '0;
			m_next = '0;
			for (i = 0; i < 16; i++) begin
				if (t_live[i] && (w[i] & m_live) != 0)
					t_next[i] = 1'b1;
				if (m_live[i] && (h[i] & t_live) != 0)
					m_next[i] = 1'b1;
			end
			changed = (t_next != t_live) || (m_next != m_live);
			t_live = t_next;
			m_live = m_next;
		end
		return (t_live | m_live) != 0;
	endfunction

	function automatic bit pick_edge(input adj_t g, output logic [3:0] row,
			output logic [3:0] col);
		bit found;
		int k;
		found = 1'b0;
		row = '0;
		col = '0;
		for (k = 0; k < 24 && !found; k++) begin
			row = 4'($urandom_range(15));
			col = 4'($urandom_range(15));
			found = g[row][col];
		end
		return found;
	endfunction

	task automatic predict_deadlock(input logic [1:0] cmd, input logic [3:0] t,
			input logic [3:0] m);
		if (latched) begin
			halted_events++;
		end else begin
			apply_event(cmd, t, m, wait_edges, hold_edges);
			if (has_cycle(wait_edges, hold_edges)) begin
				latched = 1'b1;
				latch_event = events_sent;
			end
		end
		deadlock_due_q.push_back(latched);
		cmd_count[cmd]++;
		events_sent++;
	endtask

	task automatic send_event(input logic [1:0] cmd, input logic [3:0] t,
			input logic [3:0] m);
		if (!quiet && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		thread_index <= t;
		mutex_index <= m;
		do @(posedge clk); while (!in_ready);
		predict_deadlock(cmd, t, m);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (deadlock_due_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (deadlock_due_q.size() == 0) begin
				if (mismatches < MAX_SHOWN)
					$display("unexpected result beat: deadlock=%0b", deadlock);
				mismatches++;
			end else begin
				bit due;
				due = deadlock_due_q.pop_front();
				results_checked++;
				if (deadlock !== due) begin
					if (mismatches < MAX_SHOWN)
						$display("result %0d: deadlock expected %0b, got %0b",
							results_checked - 1, due, deadlock);
					mismatches++;
				end
			end
		end
	end

	task automatic test_directed_edges();
		send_event(dwgd_pkg::CMD_ACQUIRE, 4'd0, 4'd0);
		send_event(dwgd_pkg::CMD_ACQUIRE, 4'd0, 4'd0);
		send_event(dwgd_pkg::CMD_ACQUIRED, 4'd0, 4'd0);
		send_event(dwgd_pkg::CMD_ACQUIRED, 4'd0, 4'd0);
		send_event(dwgd_pkg::CMD_RELEASE, 4'd0, 4'd0);
		send_event(dwgd_pkg::CMD_RELEASE, 4'd0, 4'd0);
		send_event(dwgd_pkg::CMD_ACQUIRE, 4'd15, 4'd15);
		send_event(dwgd_pkg::CMD_ACQUIRED, 4'd15, 4'd15);
		send_event(dwgd_pkg::CMD_RELEASE, 4'd15, 4'd15);
		send_event(CMD_UNKNOWN, 4'd15, 4'd15);
		send_event(CMD_UNKNOWN, 4'd0, 4'd0);
		// A chain of waits and holds that ends at a free mutex.
		send_event(dwgd_pkg::CMD_ACQUIRED, 4'd5, 4'd10);
		send_event(dwgd_pkg::CMD_ACQUIRE, 4'd10, 4'd10);
		send_event(dwgd_pkg::CMD_ACQUIRED, 4'd10, 4'd5);
		send_event(dwgd_pkg::CMD_ACQUIRE, 4'd5, 4'd15);
		send_event(dwgd_pkg::CMD_ACQUIRED, 4'd10, 4'd10);
		send_event(dwgd_pkg::CMD_RELEASE, 4'd5, 4'd10);
		send_event(dwgd_pkg::CMD_RELEASE, 4'd10, 4'd10);
		send_event(dwgd_pkg::CMD_RELEASE, 4'd10, 4'd5);
		send_event(dwgd_pkg::CMD_ACQUIRED, 4'd5, 4'd15);
		send_event(dwgd_pkg::CMD_RELEASE, 4'd5, 4'd15);
		send_event(dwgd_pkg::CMD_RELEASE, 4'd3, 4'd12);
		wait_results_done();
	endtask

	// Mostly lock protocol steps, with acquired and release on live edges; any step that would
	// close a cycle is turned into a release so the graph stays acyclic.
	task automatic send_random_lock_traffic(input int count);
		int n;
		int r;
		logic [1:0] cmd;
		logic [3:0] t;
		logic [3:0] m;
		adj_t w;
		adj_t h;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(99);
			t = 4'($urandom_range(15));
			m = 4'($urandom_range(15));
			if (r < 30) begin
				cmd = dwgd_pkg::CMD_ACQUIRE;
			end else if (r < 55) begin
				cmd = dwgd_pkg::CMD_ACQUIRED;
				void'(pick_edge(wait_edges, t, m));
			end else if (r < 80) begin
				cmd = dwgd_pkg::CMD_RELEASE;
				void'(pick_edge(hold_edges, m, t));
			end else begin
				cmd = 2'($urandom_range(3));
			end
			w = wait_edges;
			h = hold_edges;
			apply_event(cmd, t, m, w, h);
			if (has_cycle(w, h))
				cmd = dwgd_pkg::CMD_RELEASE;
			send_event(cmd, t, m);
		end
	endtask

	task automatic test_random_traffic();
		quiet = 1'b0;
		send_random_lock_traffic(150);
		wait_results_done();
		send_random_lock_traffic(150);
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		send_random_lock_traffic(150);
		wait_results_done();
		quiet = 1'b0;
	endtask

	task automatic test_pause_and_resume();
		send_random_lock_traffic(60);
		wait_results_done();
		repeat (20) @(posedge clk);
		send_random_lock_traffic(70);
	endtask

	task automatic test_deadlock_latch();
		int n;
		send_event(dwgd_pkg::CMD_ACQUIRED, 4'd14, 4'd14);
		send_event(dwgd_pkg::CMD_ACQUIRED, 4'd15, 4'd15);
		send_event(dwgd_pkg::CMD_ACQUIRE, 4'd14, 4'd15);
		send_event(dwgd_pkg::CMD_ACQUIRE, 4'd15, 4'd14);
		send_event(CMD_UNKNOWN, 4'd10, 4'd5);
		send_event(dwgd_pkg::CMD_RELEASE, 4'd15, 4'd15);
		for (n = 0; n < 20; n++)
			send_event(2'($urandom_range(3)), 4'($urandom_range(15)),
				4'($urandom_range(15)));
	endtask

	initial begin
		int k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_random_traffic();
		test_back_to_back();
		test_pause_and_resume();
		test_deadlock_latch();
		in_valid <= 1'b0;
		for (k = 0; k < 20000 && deadlock_due_q.size() != 0; k++)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (deadlock_due_q.size() != 0) begin
			$display("%0d expected results never arrived", deadlock_due_q.size());
			mismatches++;
		end
		$display("Sent %0d lock events (acquire %0d, acquired %0d, release %0d, unknown %0d),",
			events_sent, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
		$display("checked %0d results; deadlock latched at event %0d, %0d events while halted.",
			results_checked, latch_event, halted_events);
		if (mismatches == 0) begin
			$display("deadlock_wait_graph_detector regression: pass");
		end else begin
			$display("deadlock_wait_graph_detector regression: fail");
		end
		$finish;
	end

endmodule
